### sv/hrkf_pkg.sv
`timescale 1ns / 1ps

package hrkf_pkg;

    // Fixed-point format of the filter state
    localparam int FRAC_BITS = 32;
    localparam int ST_W      = 48;
    localparam int WIDE_W    = 50;

    typedef logic signed [ST_W-1:0]   t_st;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_st ST_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam t_st ST_MIN = 48'sh8000_0000_0000;

    localparam longint ONE_L     = longint'(1) <<< FRAC_BITS;
    localparam t_st    COV_AA_RST = t_st'(ONE_L);
    localparam t_st    COV_BB_RST = t_st'((9 * ONE_L + 5) / 10);
    localparam t_st    HEAD_LIM   = t_st'(360 * ONE_L);

    // Configuration register indexes
    localparam logic [1:0] REG_PROCESS_VAR = 2'd0;
    localparam logic [1:0] REG_MEAS_VAR    = 2'd1;
    localparam logic [1:0] REG_STEP_TIME   = 2'd2;

    localparam logic [31:0] PROCESS_VAR_RST = 32'd4734976;
    localparam logic [31:0] MEAS_VAR_RST    = 32'd65536;
    localparam logic [31:0] STEP_TIME_RST   = 32'd4294967;

    // Sequencer steps, in execution order
    typedef enum logic [4:0] {
        ST_DT2  = 5'd0,
        ST_DT3  = 5'd1,
        ST_DT4  = 5'd2,
        ST_QD11 = 5'd3,
        ST_QD12 = 5'd4,
        ST_QD22 = 5'd5,
        ST_HP   = 5'd6,
        ST_T1   = 5'd7,
        ST_T2   = 5'd8,
        ST_T3   = 5'd9,
        ST_PRED = 5'd10,
        ST_K1   = 5'd11,
        ST_K2   = 5'd12,
        ST_UH   = 5'd13,
        ST_UR   = 5'd14,
        ST_UAA  = 5'd15,
        ST_UAB  = 5'd16,
        ST_UBA  = 5'd17,
        ST_UBB  = 5'd18
    } t_step;

    typedef struct packed {
        logic  load;  // capture the new sample
        logic  go;    // start the current step
        logic  emit;  // load the output register
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic op_done;  // multiply or divide result written back
    } t_sts;

endpackage

### sv/hrkf_in_if.sv
`timescale 1ns / 1ps

interface hrkf_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] rate_sample;

    modport source (output valid, output rate_sample, input ready);
    modport sink   (input valid, input rate_sample, output ready);
endinterface

### sv/hrkf_out_if.sv
`timescale 1ns / 1ps

interface hrkf_out_if;
    logic               valid;
    logic               ready;
    logic signed [25:0] heading;
    logic signed [31:0] rate;

    modport source (output valid, output heading, output rate, input ready);
    modport sink   (input valid, input heading, input rate, output ready);
endinterface

### sv/hrkf_ctrl.sv
`timescale 1ns / 1ps

module hrkf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output hrkf_pkg::t_cmd o_cmd,
    input  hrkf_pkg::t_sts i_sts
);
    import hrkf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_step  r_step, n_step;
    logic   r_out_valid, n_out_valid;
    logic   accept, emit_ok;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign emit_ok     = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd.load  = 1'b0;
        o_cmd.go    = 1'b0;
        o_cmd.emit  = 1'b0;
        o_cmd.step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_step     = ST_DT2;
                    n_state    = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.go = 1'b1;
                if (r_step == ST_PRED) begin
                    n_step = ST_K1;  // register-only update, no wait; stay issuing
                end else begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.op_done) begin
                    if (r_step == ST_UBB) begin
                        n_state = S_FIN;
                    end else begin
                        n_step  = t_step'(r_step + 5'd1);
                        n_state = S_ISSUE;
                    end
                end
            end
            S_FIN: begin
                if (emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_DT2;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### sv/hrkf_dp.sv
`timescale 1ns / 1ps

module hrkf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hrkf_pkg::t_cmd     i_cmd,
    output hrkf_pkg::t_sts     o_sts,
    input  logic signed [15:0] i_sample,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    output logic signed [25:0] o_heading,
    output logic signed [31:0] o_rate
);
    import hrkf_pkg::*;

    function automatic t_st sat48(input logic signed [51:0] v);
        t_st res;
        if (v > 52'(ST_MAX)) begin
            res = ST_MAX;
        end else if (v < 52'(ST_MIN)) begin
            res = ST_MIN;
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

    function automatic t_st wrap_head(input t_st v);
        return (v >= HEAD_LIM || v <= -HEAD_LIM) ? '0 : v;
    endfunction

    // config
    logic [31:0] r_process_var, r_meas_var, r_step_time;

    // filter state
    t_st r_he, r_re, r_caa, r_cab, r_cba, r_cbb;
    // per-item temporaries
    t_st   r_dt2, r_dt3, r_dt4, r_qd11, r_qd12, r_qd22, r_hp, r_t1, r_t2, r_t3;
    t_st   r_a, r_b, r_c, r_d, r_k1, r_k2;
    t_wide r_ye;
    logic signed [15:0] r_sample;
    logic signed [25:0] r_heading;
    logic signed [31:0] r_rate;

    t_wide dt_w, q_w, mul_a, mul_b, s_w;
    logic  is_div, start_mul, start_div;

    assign dt_w = t_wide'({1'b0, r_step_time});
    assign q_w  = t_wide'({1'b0, r_process_var, 16'b0});
    assign s_w  = t_wide'({1'b0, r_meas_var, 16'b0}) + t_wide'(r_d);

    assign is_div    = (i_cmd.step == ST_K1) || (i_cmd.step == ST_K2);
    assign start_div = i_cmd.go && is_div;
    assign start_mul = i_cmd.go && !is_div && (i_cmd.step != ST_PRED);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.step)
            ST_DT2:  begin mul_a = dt_w;          mul_b = dt_w;          end
            ST_DT3:  begin mul_a = t_wide'(r_dt2); mul_b = dt_w;          end
            ST_DT4:  begin mul_a = t_wide'(r_dt3); mul_b = dt_w;          end
            ST_QD11: begin mul_a = q_w;           mul_b = t_wide'(r_dt4); end
            ST_QD12: begin mul_a = q_w;           mul_b = t_wide'(r_dt3); end
            ST_QD22: begin mul_a = q_w;           mul_b = t_wide'(r_dt2); end
            ST_HP:   begin mul_a = t_wide'(r_re);  mul_b = dt_w;          end
            ST_T1:   begin mul_a = dt_w;          mul_b = t_wide'(r_cbb); end
            ST_T2:   begin
                mul_a = dt_w;
                mul_b = t_wide'(r_cab) + t_wide'(r_t1);
            end
            ST_T3:   begin mul_a = dt_w;          mul_b = t_wide'(r_cba); end
            ST_UH:   begin mul_a = t_wide'(r_k1);  mul_b = r_ye;          end
            ST_UR:   begin mul_a = t_wide'(r_k2);  mul_b = r_ye;          end
            ST_UAA:  begin mul_a = t_wide'(r_k1);  mul_b = t_wide'(r_c);   end
            ST_UAB:  begin mul_a = t_wide'(r_k1);  mul_b = t_wide'(r_d);   end
            ST_UBA:  begin mul_a = t_wide'(r_k2);  mul_b = t_wide'(r_c);   end
            ST_UBB:  begin mul_a = t_wide'(r_k2);  mul_b = t_wide'(r_d);   end
            default: begin mul_a = '0;            mul_b = '0;            end
        endcase
    end

    // multiplier: 25x25 partial products
    logic [49:0]  r_mag_a, r_mag_b, r_pp;
    logic [1:0]   r_pw;
    logic [99:0]  r_acc, pp_sh;
    logic [2:0]   r_mcnt;
    logic         r_mneg, r_mbusy, r_mdone;
    logic [24:0]  part_a, part_b;
    logic [67:0]  prod_q;
    logic         prod_big;
    t_st          mul_res;

    assign part_a = r_mcnt[0] ? r_mag_a[49:25] : r_mag_a[24:0];
    assign part_b = r_mcnt[1] ? r_mag_b[49:25] : r_mag_b[24:0];

    always_comb begin
        unique case (r_pw)
            2'd0:    pp_sh = {50'b0, r_pp};
            2'd1:    pp_sh = {25'b0, r_pp, 25'b0};
            default: pp_sh = {r_pp, 50'b0};
        endcase
    end

    assign prod_q   = r_acc[99:FRAC_BITS];
    assign prod_big = |prod_q[67:47];
    always_comb begin
        if (r_mneg) begin
            mul_res = prod_big ? ST_MIN : -t_st'({1'b0, prod_q[46:0]});
        end else begin
            mul_res = prod_big ? ST_MAX : t_st'({1'b0, prod_q[46:0]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_mul) begin
            r_mag_a <= mul_a[49] ? 50'(-mul_a) : 50'(mul_a);
            r_mag_b <= mul_b[49] ? 50'(-mul_b) : 50'(mul_b);
            r_mneg  <= mul_a[49] ^ mul_b[49];
            r_acc   <= '0;
        end else if (r_mbusy) begin
            if (r_mcnt != 3'd4) begin
                r_pp <= 50'(part_a * part_b);
                r_pw <= 2'(r_mcnt[0]) + 2'(r_mcnt[1]);
            end
            if (r_mcnt != 3'd0) begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (start_mul) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 3'd1;
                if (r_mcnt == 3'd4) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    // ---------------- divider: restoring, one quotient bit per cycle --------
    t_st         div_num;
    logic [47:0] div_mag;
    logic        s_pos, div_sat;
    logic [49:0] r_rem, rem_t;
    logic [48:0] r_dsr;
    logic [47:0] r_nsh, r_quo;
    logic [5:0]  r_dcnt;
    logic        r_dneg, r_dquo, r_dbusy, r_ddone;
    t_st         r_dres, div_res;

    assign div_num = (i_cmd.step == ST_K1) ? r_b : r_d;
    assign div_mag = div_num[47] ? 48'(-div_num) : 48'(div_num);
    assign s_pos   = !s_w[49] && (s_w != '0);
    // quotient would reach 2^47: saturate without iterating
    assign div_sat = {16'b0, div_mag} >= {s_w[48:0], 15'b0};
    assign rem_t   = {r_rem[48:0], r_nsh[47]};
    assign div_res = r_dquo ? (r_dneg ? -t_st'(r_quo) : t_st'(r_quo)) : r_dres;

    always_ff @(posedge i_clk) begin
        if (start_div) begin
            r_dneg <= div_num[47];
            r_dquo <= s_pos && !div_sat;
            r_dres <= !s_pos ? '0 : (div_num[47] ? ST_MIN : ST_MAX);
            r_rem  <= {18'b0, div_mag[47:16]};
            r_nsh  <= {div_mag[15:0], 32'b0};
            r_quo  <= '0;
            r_dsr  <= s_w[48:0];
        end else if (r_dbusy) begin
            r_nsh <= {r_nsh[46:0], 1'b0};
            if (rem_t >= {1'b0, r_dsr}) begin
                r_rem <= rem_t - {1'b0, r_dsr};
                r_quo <= {r_quo[46:0], 1'b1};
            end else begin
                r_rem <= rem_t;
                r_quo <= {r_quo[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (start_div) begin
                r_dcnt <= '0;
                if (s_pos && !div_sat) begin
                    r_dbusy <= 1'b1;
                end else begin
                    r_ddone <= 1'b1;
                end
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'd47) begin
                    r_dbusy <= 1'b0;
                    r_ddone <= 1'b1;
                end
            end
        end
    end

    assign o_sts.op_done = r_mdone | r_ddone;

    // ---------------- config registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_process_var <= PROCESS_VAR_RST;
            r_meas_var    <= MEAS_VAR_RST;
            r_step_time   <= STEP_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROCESS_VAR: r_process_var <= i_cfg_data;
                REG_MEAS_VAR:    r_meas_var    <= i_cfg_data;
                REG_STEP_TIME:   r_step_time   <= i_cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- filter state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_he  <= '0;
            r_re  <= '0;
            r_caa <= COV_AA_RST;
            r_cab <= '0;
            r_cba <= '0;
            r_cbb <= COV_BB_RST;
        end else if (r_mdone) begin
            unique case (i_cmd.step)
                ST_UH:   r_he  <= wrap_head(sat48(52'(r_hp) + 52'(mul_res)));
                ST_UR:   r_re  <= sat48(52'(r_re) + 52'(mul_res));
                ST_UAA:  r_caa <= sat48(52'(r_a) - 52'(mul_res));
                ST_UAB:  r_cab <= sat48(52'(r_b) - 52'(mul_res));
                ST_UBA:  r_cba <= sat48(52'(r_c) - 52'(mul_res));
                ST_UBB:  r_cbb <= sat48(52'(r_d) - 52'(mul_res));
                default: ;
            endcase
        end
    end

    // ---------------- temporaries ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.go && i_cmd.step == ST_PRED) begin
            r_a  <= sat48(52'(r_caa) + 52'(r_t3) + 52'(r_t2) + 52'(r_qd11));
            r_b  <= sat48(52'(r_cab) + 52'(r_t1) + 52'(r_qd12));
            r_c  <= sat48(52'(r_cba) + 52'(r_t1) + 52'(r_qd12));
            r_d  <= sat48(52'(r_cbb) + 52'(r_qd22));
            r_ye <= (t_wide'(r_sample) <<< FRAC_BITS) - t_wide'(r_re);
        end
        if (r_mdone) begin
            unique case (i_cmd.step)
                ST_DT2:  r_dt2  <= mul_res;
                ST_DT3:  r_dt3  <= mul_res;
                ST_DT4:  r_dt4  <= mul_res;
                ST_QD11: r_qd11 <= (mul_res + (mul_res[47] ? 48'sd3 : 48'sd0)) >>> 2;
                ST_QD12: r_qd12 <= (mul_res + (mul_res[47] ? 48'sd1 : 48'sd0)) >>> 1;
                ST_QD22: r_qd22 <= mul_res;
                ST_HP:   r_hp   <= sat48(52'(r_he) + 52'(mul_res));
                ST_T1:   r_t1   <= mul_res;
                ST_T2:   r_t2   <= mul_res;
                ST_T3:   r_t3   <= mul_res;
                default: ;
            endcase
        end
        if (r_ddone) begin
            if (i_cmd.step == ST_K1) begin
                r_k1 <= div_res;
            end else begin
                r_k2 <= div_res;
            end
        end
    end

    // output conversion: rate to Q16.16, heading to Q10.16
    logic [47:0] he_mag, re_mag;
    logic [31:0] he_q, re_q;

    assign he_mag = r_he[47] ? 48'(-r_he) : 48'(r_he);
    assign re_mag = r_re[47] ? 48'(-r_re) : 48'(r_re);
    assign he_q   = r_he[47] ? -he_mag[47:FRAC_BITS-16] : he_mag[47:FRAC_BITS-16];
    assign re_q   = r_re[47] ? -re_mag[47:FRAC_BITS-16] : re_mag[47:FRAC_BITS-16];

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_heading <= he_q[25:0];
            r_rate    <= re_q;
        end
    end

    assign o_heading = r_heading;
    assign o_rate    = r_rate;

endmodule

### sv/heading_rate_kalman_filter.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Handshake
// i_in      in   rate_sample  s16 gyro reading             valid/ready
// o_out     out  heading s26 Q10.16, rate s32 Q16.16       valid/ready
// i_cfg_*   in   idx 2b, data 32b (process/meas/step)      write enable
//
// Each item runs 16 fixed-point multiplies on one shared 25x25
// partial-product multiplier, plus two gains on a restoring divider
// (which skips iterating when a gain saturates or is zero).
// Reset (synchronous, active low) restores registers and filter state.
// A finished result waits in the output register; the next sample is
// accepted while it waits, and only the final load stalls on o_out.ready.

module heading_rate_kalman_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hrkf_in_if.sink     i_in,
    hrkf_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import hrkf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: walks the multiply/divide steps of predict and correct
    hrkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // datapath: state, covariance, shared multiplier and divider
    hrkf_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_sample   (i_in.rate_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_heading  (o_out.heading),
        .o_rate     (o_out.rate)
    );

endmodule

### sv/hrkf_chk.sv
`timescale 1ns / 1ps

module hrkf_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [25:0] i_heading,
    input logic signed [31:0] i_rate
);

    // one sample in flight: a transfer closes the input
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while busy");

    // a result only appears at the end of a computation
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result without computation");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_heading)
            && $stable(i_rate)))
        else $error("stalled result changed");

endmodule

bind heading_rate_kalman_filter hrkf_chk u_hrkf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_heading   (o_out.heading),
    .i_rate      (o_out.rate)
);

### bench/heading_rate_kalman_filter_test.sv
`timescale 1ns / 1ps

// Bench for the heading/rate Kalman filter. A bit-exact fixed-point model of
// the filter runs beside the block: each accepted gyro sample updates the
// model, and the heading/rate it produces is queued. Every result transfer
// on o_out is checked against the oldest queued value. Registers are only
// rewritten once the block has drained.

module heading_rate_kalman_filter_test;
    import hrkf_pkg::*;

    localparam int     LIMIT_CYC = 3_000_000;
    localparam int     DRAIN_CYC = 400;        // outlasts one item's processing
    localparam longint SAT_HI    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO    = -SAT_HI - 1;
    localparam logic [1:0] REG_NONE = 2'd3;   // unused index, write is dropped

    typedef struct {
        logic signed [25:0] heading;
        logic signed [31:0] rate;
    } t_fix;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;

    hrkf_in_if  in_ch ();
    hrkf_out_if out_ch ();

    heading_rate_kalman_filter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Filter model state
    logic [31:0] m_qvar, m_rvar, m_dt;
    longint m_head, m_rate, m_paa, m_pab, m_pba, m_pbb;

    t_fix fix_queue[$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   calm = 0;          // no idling on either side while set
    int   stall_left = 0;
    logic signed [15:0] last_sample = '0;

    // ---------------- fixed-point model ----------------

    function automatic logic [63:0] mag_of(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint from_mag(logic [127:0] m, bit neg);
        if (neg) begin
            if (m > 128'(SAT_HI) + 128'd1) return SAT_LO;
            return -longint'(m[63:0]);
        end
        if (m > 128'(SAT_HI)) return SAT_HI;
        return longint'(m[63:0]);
    endfunction

    function automatic longint sat_st(longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    // (a*b) >> FRAC_BITS, truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = {64'b0, mag_of(a)} * {64'b0, mag_of(b)};
        return from_mag(p >> FRAC_BITS, (a < 0) != (b < 0));
    endfunction

    // (n << FRAC_BITS) / d, d > 0
    function automatic longint fx_div(longint n, longint d);
        logic [127:0] num;
        num = {64'b0, mag_of(n)} << FRAC_BITS;
        return from_mag(num / {64'b0, 64'(d)}, n < 0);
    endfunction

    function automatic void filter_reset();
        m_qvar = PROCESS_VAR_RST;
        m_rvar = MEAS_VAR_RST;
        m_dt   = STEP_TIME_RST;
        m_head = 0;
        m_rate = 0;
        m_paa  = ONE_L;
        m_pab  = 0;
        m_pba  = 0;
        m_pbb  = (9 * ONE_L + 5) / 10;
    endfunction

    function automatic t_fix filter_step(logic signed [15:0] smp);
        longint q, r, dt, dt2, dt3, dt4, qd11, qd12, qd22;
        longint hp, rp, a, b, c, d, ye, s, k1, k2, hq, rq, lim;
        t_fix res;
        q   = longint'(m_qvar) <<< (FRAC_BITS - 16);
        r   = longint'(m_rvar) <<< (FRAC_BITS - 16);
        dt  = longint'(m_dt);
        dt2 = fx_mul(dt, dt);
        dt3 = fx_mul(dt2, dt);
        dt4 = fx_mul(dt3, dt);
        qd11 = fx_mul(q, dt4) / 4;
        qd12 = fx_mul(q, dt3) / 2;
        qd22 = fx_mul(q, dt2);
        // predict
        hp = sat_st(m_head + fx_mul(m_rate, dt));
        rp = m_rate;
        a  = sat_st(m_paa + fx_mul(dt, m_pba) + fx_mul(dt, m_pab + fx_mul(dt, m_pbb)) + qd11);
        b  = sat_st(m_pab + fx_mul(dt, m_pbb) + qd12);
        c  = sat_st(m_pba + fx_mul(dt, m_pbb) + qd12);
        d  = sat_st(m_pbb + qd22);
        // correct; gains are zero when the innovation variance is not positive
        ye = (longint'(smp) <<< FRAC_BITS) - rp;
        s  = r + d;
        k1 = 0;
        k2 = 0;
        if (s > 0) begin
            k1 = fx_div(b, s);
            k2 = fx_div(d, s);
        end
        m_head = sat_st(hp + fx_mul(k1, ye));
        m_rate = sat_st(rp + fx_mul(k2, ye));
        m_paa  = sat_st(a - fx_mul(k1, c));
        m_pab  = sat_st(b - fx_mul(k1, d));
        m_pba  = sat_st(c - fx_mul(k2, c));
        m_pbb  = sat_st(d - fx_mul(k2, d));
        lim = 360 * ONE_L;
        if (m_head >= lim || m_head <= -lim) m_head = 0;
        hq = longint'(mag_of(m_head) >> (FRAC_BITS - 16));
        if (m_head < 0) hq = -hq;
        rq = longint'(mag_of(m_rate) >> (FRAC_BITS - 16));
        if (m_rate < 0) rq = -rq;
        if (rq > 64'sh7FFF_FFFF) rq = 64'sh7FFF_FFFF;
        if (rq < -64'sh8000_0000) rq = -64'sh8000_0000;
        res.heading = hq[25:0];
        res.rate    = rq[31:0];
        return res;
    endfunction

    // ---------------- idling ----------------

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 300);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result-side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            out_ch.ready <= 1'b1;
            stall_left   <= 0;
        end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left   <= gap_len();
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_fix exp_fix;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (fix_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: heading %0d rate %0d",
                             out_ch.heading, out_ch.rate);
            end else begin
                exp_fix = fix_queue.pop_front();
                if (out_ch.heading !== exp_fix.heading || out_ch.rate !== exp_fix.rate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: heading exp %0d got %0d, rate exp %0d got %0d",
                                 exp_fix.heading, out_ch.heading, exp_fix.rate, out_ch.rate);
                end
            end
        end
    end

    // ---------------- drivers ----------------

    // one sample transfer; the expected result is queued at the accepting edge
    task automatic send_sample(logic signed [15:0] smp);
        int gap;
        in_ch.rate_sample <= smp;
        in_ch.valid       <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        fix_queue.push_back(filter_step(smp));
        last_sample = smp;
        gap = calm ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // let the block drain completely before touching registers
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (fix_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_PROCESS_VAR: m_qvar = val;
            REG_MEAS_VAR:    m_rvar = val;
            REG_STEP_TIME:   m_dt   = val;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_filter(logic [31:0] qv, logic [31:0] rv, logic [31:0] dtv);
        drain();
        write_reg(REG_PROCESS_VAR, qv);
        write_reg(REG_MEAS_VAR, rv);
        write_reg(REG_STEP_TIME, dtv);
    endtask

    // ---------------- tests ----------------

    // field extremes under reset settings, back to back while calm
    task automatic test_extremes();
        calm = 1;
        send_sample(16'sd0);
        send_sample(16'sh7FFF);
        send_sample(-16'sh8000);
        send_sample(16'sh7FFF);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        calm = 0;
        send_sample(16'sh5555);
        send_sample(-16'sh2AAB);
    endtask

    // zero process noise, long step: heading climbs past 360 and wraps
    task automatic test_heading_wrap();
        set_filter(32'd0, 32'd1, 32'hFFFF_FFFF);
        repeat (4) send_sample(16'sh7FFF);
        repeat (4) send_sample(-16'sh8000);
        set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        repeat (3) send_sample(16'sh7FFF);
    endtask

    // zero step time; the correction alone moves the state
    task automatic test_zero_step();
        set_filter(PROCESS_VAR_RST, MEAS_VAR_RST, 32'd0);
        send_sample(16'sd100);
        send_sample(-16'sd100);
    endtask

    // R=0 and Q=0 drive cov_bb to zero, after which the gains vanish
    task automatic test_zero_innovation();
        set_filter(32'd0, 32'd0, 32'd0);
        send_sample(16'sd500);
        send_sample(-16'sd700);
        send_sample(16'sd9);
    endtask

    // an out-of-range index must leave all registers alone
    task automatic test_unused_index();
        drain();
        write_reg(REG_NONE, 32'hDEAD_BEEF);
        send_sample(16'sd42);
    endtask

    task automatic random_phase(int n);
        logic signed [15:0] smp;
        repeat (n) begin
            // mostly a smooth gyro trace, some full-range noise
            if ($urandom_range(0, 9) < 7)
                smp = last_sample + 16'($signed($urandom_range(0, 512)) - 256);
            else
                smp = 16'($urandom);
            send_sample(smp);
            if ($urandom_range(0, 99) == 0) begin
                calm = ~calm;
            end
        end
        calm = 0;
    endtask

    task automatic test_random();
        random_phase(120);
        // hold the sender until every result is back
        drain();
        random_phase(60);
        set_filter(PROCESS_VAR_RST, MEAS_VAR_RST, STEP_TIME_RST);
        random_phase(150);
        set_filter(32'hFFFF_FFFF, 32'd1, 32'd1);
        random_phase(120);
        set_filter(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(120);
        repeat (3) begin
            set_filter($urandom, $urandom_range(1, 32'hFFFF_FFFF), $urandom);
            random_phase(100);
        end
        set_filter($urandom_range(0, 32'h00FF_FFFF), $urandom_range(1, 32'h000F_FFFF),
                   $urandom_range(1, 32'h0FFF_FFFF));
        random_phase(120);
    endtask

    initial begin
        filter_reset();
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_PROCESS_VAR;
        i_cfg_data        <= '0;
        in_ch.valid       <= 1'b0;
        in_ch.rate_sample <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_heading_wrap();
        test_zero_step();
        test_zero_innovation();
        test_unused_index();
        test_random();

        drain();
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

### sim.f
sv/hrkf_pkg.sv
sv/hrkf_in_if.sv
sv/hrkf_out_if.sv
sv/hrkf_ctrl.sv
sv/hrkf_dp.sv
sv/heading_rate_kalman_filter.sv
sv/hrkf_chk.sv
bench/heading_rate_kalman_filter_test.sv
